### rtl/core/wscf_pkg.sv
// Package for the water shell count / Coulomb field block.
// Holds shared types and fixed-point constants; no dependencies.
`default_nettype none
package wscf_pkg;
  localparam int unsigned KE_Q16 = 943692;

  typedef enum logic [2:0] {
    CFG_OXY  = 3'd0,
    CFG_HYD  = 3'd1,
    CFG_SHELL = 3'd2,
    CFG_CUT  = 3'd3,
    CFG_NEAR = 3'd4
  } cfg_idx_t;

  // classified site handed from front to back
  typedef struct packed {
    logic               active;   // adds a field contribution
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [24:0] dz;
    logic [49:0]        r2;
    logic signed [17:0] q;
    logic               cnt_inc;  // oxygen inside shell
    logic               last;
  } site_t;

  typedef struct packed {
    logic [15:0] count;
    logic [31:0] mag;
    logic        sat;
  } result_t;
endpackage
`default_nettype wire

### rtl/core/water_shell_count_coulomb_field.sv
// Water shell count and Coulomb field magnitude for one query atom.
// Input channel: one water charge site per transfer (oxygen, then hydrogens),
// with the query atom position; last marks the final site of the atom.
// Output channel: one result (count, field magnitude, saturated) per last site.
// Config channel: cfg_index selects a register (0 oxygen charge, 1 hydrogen
// charge, 2 shell radius^2, 3 cutoff^2, 4 near limit^2); write only when idle.
// Flow: the front end registers offsets and squared distance, then the classified
// site, and queues up to four sites. The back end takes a site that adds no field
// and stays idle for the next one; a contributing site runs the square root, the
// weight divide, then per axis a divide, a multiply and an accumulate, using the
// bit-serial divider and square root. A last site then forms the magnitude.
// Reset (rst_n low, synchronous) restores register defaults and clears sums.
// When out_ready is low the result holds in its register and the back end
// stops taking sites; the queue then fills and in_ready drops.
`default_nettype none
module water_shell_count_coulomb_field #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_op,
  input  wire logic signed [23:0] in_atom_x,
  input  wire logic signed [23:0] in_atom_y,
  input  wire logic signed [23:0] in_atom_z,
  input  wire logic signed [23:0] in_site_x,
  input  wire logic signed [23:0] in_site_y,
  input  wire logic signed [23:0] in_site_z,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_shell_count,
  output logic [31:0]             out_field_magnitude,
  output logic                    out_saturated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import wscf_pkg::*;
  logic signed [17:0] oxy_r, hyd_r;
  logic [29:0]        shell_r, cut_r, near_r;
  site_t              f2q, q2b;
  logic               f2q_v, f2q_r, q2b_v, q2b_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oxy_r   <= -18'sd54657;
      hyd_r   <= 18'sd27329;
      shell_r <= 30'd12845056;
      cut_r   <= 30'd235929600;
      near_r  <= 30'd10486;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OXY:   oxy_r   <= cfg_data[17:0];
        CFG_HYD:   hyd_r   <= cfg_data[17:0];
        CFG_SHELL: shell_r <= cfg_data[29:0];
        CFG_CUT:   cut_r   <= cfg_data[29:0];
        CFG_NEAR:  near_r  <= cfg_data[29:0];
        default: ;
      endcase
    end
  end

  wscf_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .op(in_op), .atom_x(in_atom_x), .atom_y(in_atom_y), .atom_z(in_atom_z),
    .site_x(in_site_x), .site_y(in_site_y), .site_z(in_site_z), .last(in_last),
    .oxy_q(oxy_r), .hyd_q(hyd_r), .shell_sq(shell_r), .cut_sq(cut_r),
    .near_sq(near_r), .site_o(f2q), .site_valid(f2q_v), .site_ready(f2q_r)
  );

  wscf_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_data(f2q), .wr_valid(f2q_v), .wr_ready(f2q_r),
    .rd_data(q2b), .rd_valid(q2b_v), .rd_ready(q2b_r)
  );

  wscf_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .site_i(q2b), .site_valid(q2b_v),
    .site_ready(q2b_r), .out_valid(out_valid),
    .out_ready(out_ready), .out_shell_count(out_shell_count),
    .out_field_magnitude(out_field_magnitude), .out_saturated(out_saturated)
  );
endmodule
`default_nettype wire

### rtl/core/wscf_front.sv
// Front end: takes a site, forms the offset and squared distance, classifies it.
// Depends on wscf_pkg.
`default_nettype none
module wscf_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  op,
  input  wire logic signed [23:0]    atom_x,
  input  wire logic signed [23:0]    atom_y,
  input  wire logic signed [23:0]    atom_z,
  input  wire logic signed [23:0]    site_x,
  input  wire logic signed [23:0]    site_y,
  input  wire logic signed [23:0]    site_z,
  input  wire logic                  last,
  input  wire logic signed [17:0]    oxy_q,
  input  wire logic signed [17:0]    hyd_q,
  input  wire logic [29:0]           shell_sq,
  input  wire logic [29:0]           cut_sq,
  input  wire logic [29:0]           near_sq,
  output wscf_pkg::site_t            site_o,
  output logic                       site_valid,
  input  wire logic                  site_ready
);
  import wscf_pkg::*;
  // stage 1: offsets and squares; stage 2: classify
  logic               s1_v_r;
  logic               s1_op_r, s1_last_r;
  logic signed [24:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic [49:0]        s1_r2_r;
  logic               cut_r;
  site_t              out_r;
  logic               out_v_r;
  logic signed [24:0] dx, dy, dz;
  logic [24:0]        ax, ay, az;
  logic               s1_take, adv, in_cut;

  assign dx = 25'(site_x) - 25'(atom_x);
  assign dy = 25'(site_y) - 25'(atom_y);
  assign dz = 25'(site_z) - 25'(atom_z);
  assign ax = dx[24] ? 25'(-dx) : 25'(dx);
  assign ay = dy[24] ? 25'(-dy) : 25'(dy);
  assign az = dz[24] ? 25'(-dz) : 25'(dz);

  assign adv      = s1_v_r && (!out_v_r || site_ready);
  assign s1_take  = !s1_v_r || adv;
  assign in_ready = s1_take;
  assign site_o   = out_r;
  assign site_valid = out_v_r;
  assign in_cut   = s1_op_r ? cut_r : (s1_r2_r <= 50'(cut_sq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cut_r   <= 1'b0;
    end else begin
      if (s1_take) s1_v_r <= in_valid;
      if (adv) out_v_r <= 1'b1;
      else if (site_ready) out_v_r <= 1'b0;
      if (adv) cut_r <= s1_last_r ? 1'b0 : in_cut;
    end
    if (in_valid && s1_take) begin
      s1_op_r   <= op;
      s1_last_r <= last;
      s1_dx_r   <= dx;
      s1_dy_r   <= dy;
      s1_dz_r   <= dz;
      s1_r2_r   <= 50'(ax * ax) + 50'(ay * ay) + 50'(az * az);
    end
    if (adv) begin
      out_r.dx      <= s1_dx_r;
      out_r.dy      <= s1_dy_r;
      out_r.dz      <= s1_dz_r;
      out_r.r2      <= s1_r2_r;
      out_r.q       <= s1_op_r ? hyd_q : oxy_q;
      out_r.last    <= s1_last_r;
      out_r.cnt_inc <= !s1_op_r && (s1_r2_r < 50'(shell_sq));
      out_r.active  <= in_cut && (s1_r2_r != '0) && (s1_r2_r >= 50'(near_sq))
                       && ((s1_op_r ? hyd_q : oxy_q) != '0);
    end
  end
endmodule
`default_nettype wire

### rtl/core/wscf_fifo.sv
// Short queue between front and back ends.
// Depends on wscf_pkg.
`default_nettype none
module wscf_fifo (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire wscf_pkg::site_t wr_data,
  input  wire logic        wr_valid,
  output logic             wr_ready,
  output wscf_pkg::site_t  rd_data,
  output logic             rd_valid,
  input  wire logic        rd_ready
);
  import wscf_pkg::*;
  site_t      mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 3'd4;
  assign rd_valid = cnt_r != 3'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

### rtl/core/wscf_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// No package dependency.
`default_nettype none
module wscf_sqrt #(
  parameter int unsigned IW = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [IW-1:0]   val,
  output logic [IW/2-1:0]      root
);
  localparam int unsigned RW = IW / 2;
  localparam int unsigned CW = $clog2(RW + 1);
  logic [IW-1:0]   rem_r;
  logic [IW-1:0]   src_r;
  logic [RW-1:0]   root_r;
  logic [CW-1:0]   n_r;
  logic            busy_r;
  logic [IW+1:0]   trial, remsh;

  assign remsh = {rem_r, src_r[IW-1:IW-2]};
  assign trial = {IW'(root_r), 2'b01};
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        n_r    <= CW'(RW);
        rem_r  <= '0;
        root_r <= '0;
        src_r  <= val;
      end else if (busy_r) begin
        src_r <= {src_r[IW-3:0], 2'b00};
        if (remsh >= trial) begin
          rem_r  <= IW'(remsh - trial);
          root_r <= {root_r[RW-2:0], 1'b1};
        end else begin
          rem_r  <= IW'(remsh);
          root_r <= {root_r[RW-2:0], 1'b0};
        end
        n_r <= n_r - CW'(1);
        if (n_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/wscf_back.sv
// Back end: per-site field terms by sequenced arithmetic, accumulation, result.
// Depends on wscf_pkg and wscf_sqrt.
`default_nettype none
module wscf_back #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire wscf_pkg::site_t  site_i,
  input  wire logic             site_valid,
  output logic                  site_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [15:0]           out_shell_count,
  output logic [31:0]           out_field_magnitude,
  output logic                  out_saturated
);
  import wscf_pkg::*;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam logic [31:0] CEIL = (COUNT_WIDTH < 16) ? 32'(CMAX) : 32'd65535;
  localparam logic signed [47:0] AMAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] AMIN = {1'b1, 47'd0};

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_RT  = 9'b000000010, S_WD  = 9'b000000100,
    S_FD   = 9'b000001000, S_ML  = 9'b000010000, S_ACC = 9'b000100000,
    S_SQ   = 9'b001000000, S_MS  = 9'b010000000, S_OUT = 9'b100000000
  } st_t;
  st_t st_r;

  site_t               s_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic signed [47:0]  acc_r [3];
  logic [1:0]          ax_r;
  logic [31:0]         rr_r;
  logic [57:0]         w_r;
  logic [63:0]         f_r;
  logic [105:0]        prod_r;
  logic [1:0]          pp_r;
  logic [63:0]         sum_r;
  logic                big_r;
  logic                res_v_r;
  result_t             res_r;

  // shared restoring divider: quotient one bit per cycle
  logic [127:0] dnum_r;
  logic [63:0]  dden_r, drem_r, dq_r;
  logic [6:0]   dn_r;
  logic [64:0]  dtry;
  logic         dfit;
  logic [63:0]  drem_nxt, dq_nxt;

  logic         sq_start;
  logic [63:0]  sq_val;
  logic [31:0]  sq_root;
  logic [6:0]   sq_cnt_r;

  logic signed [24:0] dcur;
  logic               neg;
  logic signed [48:0] nsum;
  logic [57:0]        aq;
  logic [31:0]        amag;
  logic [31:0]        cnt32;
  logic               cnt_clip;

  assign dcur  = (ax_r == 2'd0) ? s_r.dx : (ax_r == 2'd1) ? s_r.dy : s_r.dz;
  assign neg   = s_r.q[17] != dcur[24];
  assign aq    = 58'((s_r.q[17] ? 18'(-s_r.q) : 18'(s_r.q)) * KE_Q16);
  assign dtry  = {drem_r, dnum_r[127]} ;
  assign dfit  = dtry >= {1'b0, dden_r};
  assign drem_nxt = dfit ? 64'(dtry - {1'b0, dden_r}) : dtry[63:0];
  assign dq_nxt   = {dq_r[62:0], dfit};
  assign nsum  = neg ? 49'(acc_r[ax_r]) - 49'(prod_r[105:42])
                     : 49'(acc_r[ax_r]) + 49'(prod_r[105:42]);
  assign amag  = acc_r[ax_r][47] ? 32'(-acc_r[ax_r]) : 32'(acc_r[ax_r]);
  assign cnt32    = 32'(cnt_r);
  assign cnt_clip = cnt32 >= CEIL;

  assign site_ready = (st_r == S_IDLE) && !res_v_r;
  assign out_valid  = res_v_r;
  assign out_shell_count     = res_r.count;
  assign out_field_magnitude = res_r.mag;
  assign out_saturated       = res_r.sat;

  assign sq_start = (st_r == S_IDLE && site_valid && site_ready && site_i.active)
                  || (st_r == S_MS && ax_r == 2'd3);
  assign sq_val   = (st_r == S_IDLE) ? 64'(site_i.r2) : sum_r;

  wscf_sqrt #(.IW(64)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .val(sq_val),
    .root(sq_root)
  );

  function automatic logic big_acc(input logic signed [47:0] a);
    logic [47:0] m;
    m = a[47] ? 48'(-a) : 48'(a);
    return m[47:32] != '0;
  endfunction

  function automatic logic [24:0] adcur_for(input logic [1:0] a);
    logic signed [24:0] d;
    d = (a == 2'd0) ? s_r.dx : (a == 2'd1) ? s_r.dy : s_r.dz;
    return d[24] ? 25'(-d) : 25'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      res_v_r <= 1'b0;
      cnt_r   <= '0;
      acc_r[0] <= '0; acc_r[1] <= '0; acc_r[2] <= '0;
    end else begin
      if (res_v_r && out_ready) res_v_r <= 1'b0;
      case (st_r)
        S_IDLE: if (site_valid && site_ready) begin
          s_r <= site_i;
          if (site_i.cnt_inc && cnt_r != CMAX) cnt_r <= cnt_r + 1'b1;
          sq_cnt_r <= 7'd33;
          if (site_i.active) st_r <= S_RT;
          else if (site_i.last) begin
            ax_r <= 2'd0; sum_r <= '0; big_r <= 1'b0; st_r <= S_MS;
          end
        end
        S_RT: begin
          sq_cnt_r <= sq_cnt_r - 7'd1;
          if (sq_cnt_r == 7'd1) begin
            rr_r   <= sq_root;
            dnum_r <= {54'd0, aq, 16'd0};
            dden_r <= 64'(s_r.r2);
            drem_r <= '0; dq_r <= '0; dn_r <= 7'd0;
            st_r   <= S_WD;
          end
        end
        S_WD, S_FD: begin
          if (dn_r != 7'd127) begin
            drem_r <= drem_nxt;
            dq_r   <= dq_nxt;
            dnum_r <= {dnum_r[126:0], 1'b0};
            dn_r   <= dn_r + 7'd1;
          end else if (st_r == S_WD) begin
            // full 128-bit dividend consumed: weight done, start axis 0
            w_r    <= 58'(dq_nxt);
            ax_r   <= 2'd0;
            dden_r <= 64'(rr_r);
            drem_r <= '0; dq_r <= '0; dn_r <= 7'd0;
            dnum_r <= {64'd0, 9'd0, adcur_for(2'd0), 30'd0};
            st_r   <= S_FD;
          end else begin
            f_r    <= dq_nxt;
            pp_r   <= 2'd0; prod_r <= '0; st_r <= S_ML;
          end
        end
        S_ML: begin
          // 58x64 product from four 32x32-scale partial products
          case (pp_r)
            2'd0: prod_r <= 106'(w_r[31:0] * f_r[31:0]);
            2'd1: prod_r <= prod_r + (106'(w_r[31:0] * f_r[63:32]) << 32);
            2'd2: prod_r <= prod_r + (106'(w_r[57:32] * f_r[31:0]) << 32);
            default: prod_r <= prod_r + (106'(w_r[57:32] * f_r[63:32]) << 64);
          endcase
          pp_r <= pp_r + 2'd1;
          if (pp_r == 2'd3) st_r <= S_ACC;
        end
        S_ACC: begin
          if (nsum > 49'(AMAX)) acc_r[ax_r] <= AMAX;
          else if (nsum < 49'(AMIN)) acc_r[ax_r] <= AMIN;
          else acc_r[ax_r] <= nsum[47:0];
          if (ax_r == 2'd2) begin
            if (s_r.last) begin
              ax_r <= 2'd0; sum_r <= '0; big_r <= 1'b0; st_r <= S_MS;
            end else st_r <= S_IDLE;
          end else begin
            ax_r   <= ax_r + 2'd1;
            dden_r <= 64'(rr_r);
            drem_r <= '0; dq_r <= '0; dn_r <= 7'd0;
            dnum_r <= {64'd0, 9'd0, adcur_for(ax_r + 2'd1), 30'd0};
            st_r   <= S_FD;
          end
        end
        S_MS: begin
          if (ax_r == 2'd3) begin
            sq_cnt_r <= 7'd33;
            st_r <= S_SQ;
          end else begin
            if (big_acc(acc_r[ax_r])) big_r <= 1'b1;
            else if (65'(sum_r) + 65'(amag * amag) > 65'(64'hFFFF_FFFF_FFFF_FFFF))
              big_r <= 1'b1;
            sum_r <= sum_r + 64'(amag * amag);
            ax_r  <= ax_r + 2'd1;
          end
        end
        S_SQ: begin
          sq_cnt_r <= sq_cnt_r - 7'd1;
          if (sq_cnt_r == 7'd1) st_r <= S_OUT;
        end
        S_OUT: begin
          res_r.count <= cnt_clip ? CEIL[15:0] : cnt32[15:0];
          res_r.mag   <= (big_r || sq_root == '1) ? 32'hFFFF_FFFF : sq_root;
          res_r.sat   <= big_r || sq_root == '1 || cnt_clip;
          res_v_r <= 1'b1;
          cnt_r <= '0;
          acc_r[0] <= '0; acc_r[1] <= '0; acc_r[2] <= '0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/wscf_checker.sv
// Port-level checker for the water shell/field block, bound to the top level.
// No package dependency.
`default_nettype none
module wscf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_field_magnitude,
  input wire logic        out_saturated
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_field_magnitude))
    else $error("result dropped while stalled");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_magnitude == 32'hFFFF_FFFF |-> out_saturated)
    else $error("ceiling magnitude without saturated");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule
bind water_shell_count_coulomb_field wscf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_field_magnitude(out_field_magnitude), .out_saturated(out_saturated)
);
`default_nettype wire
